[sv/csfw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package csfw_pkg;

  // Field widths and queue geometry
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned PID_W       = 8;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [OCC_W-1:0]   OCC_FULL  = OCC_W'(QUEUE_DEPTH);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd3;

  // Request payload
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PID_W-1:0]  pid;
  } req_t;

  // Result payload
  typedef struct packed {
    logic               acquired;
    logic               woken_valid;
    logic [PID_W-1:0]   woken_pid;
    logic               is_waiting;
    logic [COUNT_W-1:0] current_count;
    logic [OCC_W-1:0]   queued;
    logic               overflow;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // apply the op and register the result
  } ctrl_t;

endpackage
`default_nettype wire

[sv/csfw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module csfw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            done_o,
  output csfw_pkg::ctrl_t ctrl_o
);
  import csfw_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;
  assign done_o = (state_q == ST_RESP);

  assign ctrl_o.load = accept;
  assign ctrl_o.exec = (state_q == ST_EXEC);

  // Next state: a new op may enter while the previous result is shown
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: state_d = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = accept ? ST_EXEC : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[sv/csfw_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module csfw_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  csfw_pkg::ctrl_t                ctrl_i,
  input  csfw_pkg::req_t                 req_i,
  input  logic [csfw_pkg::COUNT_W-1:0]   init_count_i,
  output csfw_pkg::rsp_t                 rsp_o
);
  import csfw_pkg::*;

  // Captured request
  logic [FUNC_W-1:0] func_q;
  logic [PID_W-1:0]  pid_q;

  // Semaphore state
  logic [COUNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [PID_W-1:0]   queue_q [QUEUE_DEPTH];
  logic               push;

  // Result registers
  logic                   acquired_d, acquired_q;
  logic                   woken_d, woken_q;
  logic [PID_W-1:0]       woken_pid_d, woken_pid_q;
  logic                   overflow_d, overflow_q;
  logic [QUEUE_DEPTH-1:0] hit_d, hit_q;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      func_q <= req_i.func;
      pid_q  <= req_i.pid;
    end
  end

  // Op decode and state update
  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    push        = 1'b0;
    acquired_d  = 1'b0;
    woken_d     = 1'b0;
    woken_pid_d = '0;
    overflow_d  = 1'b0;
    unique case (func_q)
      FUNC_WAIT: begin
        if (count_q != '0) begin
          count_d    = count_q - COUNT_W'(1);
          acquired_d = 1'b1;
        end else if (occ_q == OCC_FULL) begin
          overflow_d = 1'b1;
        end else begin
          push   = 1'b1;
          tail_d = tail_q + PTR_W'(1);
          occ_d  = occ_q + OCC_W'(1);
        end
      end
      FUNC_SIGNAL: begin
        if (occ_q != '0) begin
          woken_d     = 1'b1;
          woken_pid_d = queue_q[head_q];
          head_d      = head_q + PTR_W'(1);
          occ_d       = occ_q - OCC_W'(1);
        end else if (count_q != COUNT_MAX) begin
          count_d = count_q + COUNT_W'(1);
        end
      end
      FUNC_QUERY: begin
      end
      FUNC_REINIT: begin
        count_d = init_count_i;
        head_d  = '0;
        tail_d  = '0;
        occ_d   = '0;
      end
      default: begin
      end
    endcase
  end

  // Query: parallel compare over occupied slots, reduced next cycle
  always_comb begin
    logic [PTR_W-1:0] offs;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      offs     = PTR_W'(i) - head_q;
      hit_d[i] = (func_q == FUNC_QUERY) && ({1'b0, offs} < occ_q) && (queue_q[i] == pid_q);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
    end else if (ctrl_i.exec) begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
    end
  end

  // Queue storage and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (push) begin
        queue_q[tail_q] <= pid_q;
      end
      acquired_q  <= acquired_d;
      woken_q     <= woken_d;
      woken_pid_q <= woken_pid_d;
      overflow_q  <= overflow_d;
      hit_q       <= hit_d;
    end
  end

  assign rsp_o.acquired      = acquired_q;
  assign rsp_o.woken_valid   = woken_q;
  assign rsp_o.woken_pid     = woken_pid_q;
  assign rsp_o.is_waiting    = |hit_q;
  assign rsp_o.current_count = count_q;
  assign rsp_o.queued        = occ_q;
  assign rsp_o.overflow      = overflow_q;

endmodule
`default_nettype wire

[sv/counting_semaphore_fifo_waiters_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel    | Ports                                   | Transfer
// -----------+-----------------------------------------+----------------------------
// request    | start, busy, req_i                      | start high while busy low
// result     | done_o, rsp_o                           | done_o high, one cycle
// register   | psel, penable, pwrite, paddr, pwdata,   | psel, penable, pwrite, pready
//            | prdata, pready                          |
//
// Each op passes through an execute state that updates the count and
// the 16-entry wait queue, then a result state with the result on rsp_o.
// A new request is taken during the result state, so ops can issue back to back.
// The queue search is a parallel compare registered in the execute cycle.
// Reset clears count, pointers, occupancy and the reload register; queue data
// is left as is. The result side cannot stall.
module counting_semaphore_fifo_waiters_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  csfw_pkg::req_t       req_i,
  output logic                 done_o,
  output csfw_pkg::rsp_t       rsp_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import csfw_pkg::*;

  ctrl_t              ctrl;
  logic [COUNT_W-1:0] init_count_q;
  logic               reg_sel;

  // Register port: one register, selected whenever paddr[2] is 0 (addresses 0 to 3)
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {{(32-COUNT_W){1'b0}}, init_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_count_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      init_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  csfw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  csfw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .req_i        (req_i),
    .init_count_i (init_count_q),
    .rsp_o        (rsp_o)
  );

  // Result always follows an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result without execute cycle");

  // Execute lasts exactly one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |=> !busy)
    else $error("execute cycle repeated");

  // Occupancy shown with a result never exceeds the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> rsp_o.queued <= OCC_FULL)
    else $error("queue occupancy out of range");

  // Grant, wake and overflow are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({rsp_o.acquired, rsp_o.woken_valid, rsp_o.overflow}))
    else $error("conflicting result flags");

endmodule
`default_nettype wire
